/* design/fts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_pkg
// Shared widths, constants and control types of the frame time smoother.
// ----------------------------------------------------------------------------
package fts_pkg;

	// field widths
	localparam int TICKS_W     = 40;
	localparam int US_W        = 24;
	localparam int WLEN_OUT_W  = 7;
	localparam int TICK_RATE_W = 32;
	localparam int FIXED_W     = 21;
	localparam int MAX_STEP_W  = 20;
	localparam int SCALE_W     = 16;
	localparam int WINDOW_W    = 20;
	localparam int HIST_W      = 19;

	// history depth and derived widths
	localparam int DEPTH   = 64;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WLEN_W  = $clog2(DEPTH + 1);
	localparam int SUM_W   = HIST_W + $clog2(DEPTH);

	// arithmetic widths
	localparam int PROD_W  = 60;                      // ticks * 1e6
	localparam int SPROD_W = MAX_STEP_W + SCALE_W;    // base * scale
	localparam int WNUM_W  = US_W + 1;                // 2*window + last
	localparam int DIV_NW  = PROD_W;                  // divider dividend
	localparam int DIV_DW  = TICK_RATE_W;             // divider divisor
	localparam int ITER_W  = $clog2(DIV_NW + 1);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd5;

	// constants
	localparam logic [US_W-1:0]   SAT24        = 24'hFFFFFF;
	localparam logic [HIST_W-1:0] CLIP_US      = 19'd400000;
	localparam logic [HIST_W-1:0] SMALL_US     = 19'd100;
	localparam logic [HIST_W-1:0] INIT_US      = 19'd33333;
	localparam logic [19:0]       USEC_PER_SEC = 20'd1000000;

	// register reset values
	localparam logic [TICK_RATE_W-1:0] RST_TICK_RATE = 32'd1000000;
	localparam logic [MAX_STEP_W-1:0]  RST_MAX_STEP  = 20'd250000;
	localparam logic [SCALE_W-1:0]     RST_SCALE     = 16'd256;
	localparam logic [WINDOW_W-1:0]    RST_WINDOW    = 20'd250000;

	// shared divider operation
	typedef enum logic [1:0] {
		DIV_REAL,
		DIV_WIN,
		DIV_MEAN
	} fts_divop_t;

	// controller to datapath
	typedef struct packed {
		logic       in_load;
		logic       div_start;
		fts_divop_t div_op;
		logic       real_load;
		logic       scale_load;
		logic       frame_load;
		logic       hist_wr;
		logic       win_load;
		logic       sum_rd;
		logic       avg_load;
		logic       out_load;
	} fts_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic smooth_on;
		logic sum_last;
	} fts_sts_t;

endpackage

/* design/fts_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_if
// Valid/ready channels of the frame time smoother: sample in, result out.
// ----------------------------------------------------------------------------
interface fts_in_if import fts_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TICKS_W-1:0] elapsed_ticks;

	modport source (output valid, output elapsed_ticks, input ready);
	modport sink (input valid, input elapsed_ticks, output ready);
endinterface

interface fts_out_if import fts_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [US_W-1:0]       frame_us;
	logic [US_W-1:0]       real_us;
	logic [WLEN_OUT_W-1:0] window_len;

	modport source (output valid, output frame_us, output real_us, output window_len,
		input ready);
	modport sink (input valid, input frame_us, input real_us, input window_len,
		output ready);
endinterface

/* design/fts_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_div
// Shared radix-2 restoring divider, one quotient bit per cycle, with a
// run length chosen per operation.
// ----------------------------------------------------------------------------
module fts_div import fts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ITER_W-1:0] iters,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic [DIV_NW-1:0] quotient,
	output logic              done
);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] left_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;

	logic [ITER_W-1:0] shamt;
	logic [DIV_DW:0]   trial;
	logic              fits;

	// align the dividend so its top used bit leaves first
	assign shamt = ITER_W'(DIV_NW) - iters;
	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign fits  = (trial >= {1'b0, den_q});

	// sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			left_q <= iters;
		end else if (busy_q) begin
			left_q <= left_q - ITER_W'(1);
			if (left_q == ITER_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// shift in one dividend bit, subtract where it fits
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend << shamt;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-2:0], fits};
			rem_q <= fits ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
		end
	end

	assign quotient = num_q;
	assign done     = done_q;

endmodule

/* design/fts_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_dpath
// Datapath: configuration registers, tick conversion, frame conditioning,
// history memory, window sum and the shared divider.
// ----------------------------------------------------------------------------
module fts_dpath import fts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [TICKS_W-1:0]    ticks,
	input  fts_cmd_t              cmd,
	output fts_sts_t              sts,
	output logic [US_W-1:0]       frame_us,
	output logic [US_W-1:0]       real_us,
	output logic [WLEN_OUT_W-1:0] window_len
);

	// configuration
	logic [TICK_RATE_W-1:0] tick_rate_q;
	logic [FIXED_W-1:0]     fixed_q;
	logic [MAX_STEP_W-1:0]  max_step_q;
	logic [SCALE_W-1:0]     scale_q;
	logic                   smooth_q;
	logic [WINDOW_W-1:0]    window_q;

	// state
	logic [US_W-1:0]   last_q;
	logic [ADDR_W-1:0] head_q;
	logic [WLEN_W-1:0] cnt_q;
	logic [HIST_W-1:0] hist_mem [DEPTH];

	// per-item working registers
	logic [PROD_W-1:0]  prod_q;
	logic [US_W-1:0]    real_q;
	logic [SPROD_W-1:0] sprod_q;
	logic [US_W-1:0]    frame_q;
	logic [HIST_W-1:0]  clip_q;
	logic [WLEN_W-1:0]  w_q;
	logic [WLEN_W-1:0]  idx_q;
	logic [SUM_W-1:0]   acc_q;
	logic               rd_s1;
	logic               age_ok_s1;
	logic [HIST_W-1:0]  rd_data_s1;

	// output register
	logic [US_W-1:0]       out_frame_q;
	logic [US_W-1:0]       out_real_q;
	logic [WLEN_OUT_W-1:0] out_wlen_q;

	// divider hookup
	logic [ITER_W-1:0] div_iters;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [DIV_NW-1:0] div_quo;
	logic              div_done;

	// combinational results
	logic [PROD_W-1:0]     prod_nxt;
	logic [US_W-1:0]       real_nxt;
	logic [MAX_STEP_W-1:0] base;
	logic [SPROD_W-1:0]    sprod_nxt;
	logic [SPROD_W-9:0]    scaled;
	logic [US_W-1:0]       scaled_sat;
	logic [FIXED_W-1:0]    fixed_mag;
	logic [US_W-1:0]       frame_nxt;
	logic [HIST_W-1:0]     clip_nxt;
	logic [WLEN_W-1:0]     w_nxt;
	logic [HIST_W-1:0]     avg_nxt;
	logic [ADDR_W-1:0]     head_nxt;
	logic [ADDR_W-1:0]     age;
	logic [ADDR_W-1:0]     rd_addr;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= RST_TICK_RATE;
			fixed_q     <= '0;
			max_step_q  <= RST_MAX_STEP;
			scale_q     <= RST_SCALE;
			smooth_q    <= 1'b1;
			window_q    <= RST_WINDOW;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TICK_RATE: tick_rate_q <= cfg_data[TICK_RATE_W-1:0];
				CFG_FIXED:     fixed_q     <= cfg_data[FIXED_W-1:0];
				CFG_MAX_STEP:  max_step_q  <= cfg_data[MAX_STEP_W-1:0];
				CFG_SCALE:     scale_q     <= cfg_data[SCALE_W-1:0];
				CFG_SMOOTH:    smooth_q    <= cfg_data[0];
				CFG_WINDOW:    window_q    <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	// ticks to microseconds numerator
	assign prod_nxt = PROD_W'(ticks) * PROD_W'(USEC_PER_SEC);

	// saturate the converted time; zero rate saturates too
	assign real_nxt = ((tick_rate_q == '0) || (div_quo > DIV_NW'(SAT24))) ?
		SAT24 : div_quo[US_W-1:0];

	// clamp to max step, then scale
	assign base      = (real_q < US_W'(max_step_q)) ? real_q[MAX_STEP_W-1:0] : max_step_q;
	assign sprod_nxt = SPROD_W'(base) * SPROD_W'(scale_q);
	assign scaled    = sprod_q[SPROD_W-1:8];
	assign scaled_sat = (scaled > (SPROD_W-8)'(SAT24)) ? SAT24 : scaled[US_W-1:0];

	// magnitude of the fixed step
	assign fixed_mag = fixed_q[FIXED_W-1] ? (~fixed_q + FIXED_W'(1)) : fixed_q;
	assign frame_nxt = (fixed_q != '0) ? US_W'(fixed_mag) : scaled_sat;
	assign clip_nxt  = (frame_nxt > US_W'(CLIP_US)) ? CLIP_US : frame_nxt[HIST_W-1:0];

	// window length from the divider quotient
	always_comb begin
		if (last_q == '0) begin
			w_nxt = WLEN_W'(1);
		end else if (div_quo > DIV_NW'(DEPTH)) begin
			w_nxt = WLEN_W'(DEPTH);
		end else if (div_quo == '0) begin
			w_nxt = WLEN_W'(1);
		end else begin
			w_nxt = div_quo[WLEN_W-1:0];
		end
	end

	// mean, or the sample itself when it is small
	assign avg_nxt = (clip_q < SMALL_US) ? clip_q : div_quo[HIST_W-1:0];

	// divider operand select
	always_comb begin
		case (cmd.div_op)
			DIV_REAL: begin
				div_iters = ITER_W'(PROD_W);
				div_num   = prod_q;
				div_den   = tick_rate_q;
			end
			DIV_WIN: begin
				div_iters = ITER_W'(WNUM_W);
				div_num   = DIV_NW'({window_q, 1'b0}) + DIV_NW'(last_q);
				div_den   = DIV_DW'({last_q, 1'b0});
			end
			DIV_MEAN: begin
				div_iters = ITER_W'(SUM_W);
				div_num   = DIV_NW'(acc_q);
				div_den   = DIV_DW'(w_q);
			end
			default: begin
				div_iters = ITER_W'(PROD_W);
				div_num   = prod_q;
				div_den   = tick_rate_q;
			end
		endcase
	end

	fts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.iters    (div_iters),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.done     (div_done)
	);

	// per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.in_load)    prod_q  <= prod_nxt;
		if (cmd.real_load)  real_q  <= real_nxt;
		if (cmd.scale_load) sprod_q <= sprod_nxt;
		if (cmd.frame_load) begin
			frame_q <= frame_nxt;
			clip_q  <= clip_nxt;
		end
		if (cmd.win_load)   w_q     <= w_nxt;
		if (cmd.avg_load)   frame_q <= US_W'(avg_nxt);
	end

	// history ring: head points at the newest entry
	assign head_nxt = (head_q == ADDR_W'(DEPTH - 1)) ? '0 : head_q + ADDR_W'(1);
	assign age      = idx_q[ADDR_W-1:0];
	assign rd_addr  = (head_q >= age) ? (head_q - age) :
		ADDR_W'((ADDR_W+1)'(head_q) + (ADDR_W+1)'(DEPTH) - (ADDR_W+1)'(age));

	// ring pointer, fill count and last average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			last_q <= US_W'(INIT_US);
		end else begin
			if (cmd.hist_wr) begin
				head_q <= head_nxt;
				if (cnt_q != WLEN_W'(DEPTH)) begin
					cnt_q <= cnt_q + WLEN_W'(1);
				end
			end
			if (cmd.avg_load) begin
				last_q <= US_W'(avg_nxt);
			end
		end
	end

	// history memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.hist_wr) begin
			hist_mem[head_nxt] <= clip_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= hist_mem[rd_addr];
		age_ok_s1  <= (idx_q < cnt_q);
	end

	// walk the window, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			idx_q <= '0;
		end else begin
			rd_s1 <= cmd.sum_rd;
			if (cmd.win_load) begin
				idx_q <= '0;
			end else if (cmd.sum_rd) begin
				idx_q <= idx_q + WLEN_W'(1);
			end
		end
	end

	// accumulate; entries never written read as the reset value
	always_ff @(posedge clk) begin
		if (cmd.win_load) begin
			acc_q <= '0;
		end else if (rd_s1) begin
			acc_q <= acc_q + SUM_W'(age_ok_s1 ? rd_data_s1 : INIT_US);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_frame_q <= frame_q;
			out_real_q  <= real_q;
			out_wlen_q  <= smooth_q ? WLEN_OUT_W'(w_q) : '0;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.smooth_on = smooth_q;
	assign sts.sum_last  = (idx_q == (w_q - WLEN_W'(1)));

	assign frame_us   = out_frame_q;
	assign real_us    = out_real_q;
	assign window_len = out_wlen_q;

endmodule

/* design/fts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_ctrl
// Controller: sequences one item through conversion and conditioning and, with
// smoothing on, window sum and mean, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module fts_ctrl import fts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  fts_sts_t sts,
	output fts_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_RDIV_GO   = 4'd1;
	localparam logic [3:0] ST_RDIV_WAIT = 4'd2;
	localparam logic [3:0] ST_SCALE     = 4'd3;
	localparam logic [3:0] ST_FRAME     = 4'd4;
	localparam logic [3:0] ST_WDIV_GO   = 4'd5;
	localparam logic [3:0] ST_WDIV_WAIT = 4'd6;
	localparam logic [3:0] ST_SUM       = 4'd7;
	localparam logic [3:0] ST_SUM_END   = 4'd8;
	localparam logic [3:0] ST_MDIV_GO   = 4'd9;
	localparam logic [3:0] ST_MDIV_WAIT = 4'd10;
	localparam logic [3:0] ST_FIN       = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_vld_q;
	logic       out_free;

	assign out_free = !out_vld_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.div_op = DIV_REAL;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_nxt   = ST_RDIV_GO;
				end
			end
			ST_RDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_REAL;
				state_nxt     = ST_RDIV_WAIT;
			end
			ST_RDIV_WAIT: begin
				if (sts.div_done) begin
					cmd.real_load = 1'b1;
					state_nxt     = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale_load = 1'b1;
				state_nxt      = ST_FRAME;
			end
			ST_FRAME: begin
				cmd.frame_load = 1'b1;
				state_nxt      = sts.smooth_on ? ST_WDIV_GO : ST_FIN;
			end
			ST_WDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_WIN;
				cmd.hist_wr   = 1'b1;
				state_nxt     = ST_WDIV_WAIT;
			end
			ST_WDIV_WAIT: begin
				cmd.div_op = DIV_WIN;
				if (sts.div_done) begin
					cmd.win_load = 1'b1;
					state_nxt    = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum_rd = 1'b1;
				if (sts.sum_last) begin
					state_nxt = ST_SUM_END;
				end
			end
			ST_SUM_END: begin
				state_nxt = ST_MDIV_GO;
			end
			ST_MDIV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_MEAN;
				state_nxt     = ST_MDIV_WAIT;
			end
			ST_MDIV_WAIT: begin
				cmd.div_op = DIV_MEAN;
				if (sts.div_done) begin
					cmd.avg_load = 1'b1;
					state_nxt    = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;

endmodule

/* design/frame_time_smoother_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_smoother_unit
// Converts per-frame tick counts to microseconds and smooths frame time.
// ----------------------------------------------------------------------------
// Use: each item on the sample channel carries the ticks elapsed since the
// previous frame; each item on the result channel carries the conditioned
// frame time, the raw converted time and the number of history entries
// averaged. The user must write registers on the cfg port only while the
// block is idle; the block itself does not enforce this. One item is worked
// at a time. A single shared divider, one quotient bit per cycle, runs the
// tick conversion and, with smoothing on, the window length and the mean;
// the window sum reads the averaged entries one by one from the history
// memory read port. The next item is accepted in the cycle after the result
// is loaded. The result sits in an output register, so the next item is
// taken while it waits; if the receiver still stalls when the next result
// is ready, the block holds that result and stops accepting until the
// register frees. Reset restores the register defaults, sets the last
// average to 33333 us and empties the history fill count, so unwritten
// entries read as 33333.
// ----------------------------------------------------------------------------
module frame_time_smoother_unit import fts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fts_in_if.sink                sample,
	fts_out_if.source             result
);

	fts_cmd_t cmd;
	fts_sts_t sts;

	fts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fts_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.ticks      (sample.elapsed_ticks),
		.cmd        (cmd),
		.sts        (sts),
		.frame_us   (result.frame_us),
		.real_us    (result.real_us),
		.window_len (result.window_len)
	);

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frame_time_smoother_unit. Elapsed tick counts go in
// on the sample channel. A scoreboard class keeps its own copy of the register
// set, the frame history and the running average, and works out the frame
// time, real time and window length for every accepted item. It then compares
// each returned item with the oldest prediction. A short directed part covers
// saturation, the fixed step, zero rate, zero average, small samples and
// smoothing off. Random phases with fresh register settings follow, under
// three idling profiles on the two channels.
// ----------------------------------------------------------------------------
module tb;
	import fts_pkg::*;

	localparam int CLK_HALF  = 10;
	localparam int LIMIT     = 1500000;
	localparam int SEGMENTS  = 10;
	localparam int SEG_ITEMS = 100;
	localparam int REPORT_N  = 10;

	typedef struct packed {
		logic [US_W-1:0]       frame_us;
		logic [US_W-1:0]       real_us;
		logic [WLEN_OUT_W-1:0] window_len;
	} frame_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: register copy, history model and queue of expected items
	// ------------------------------------------------------------------------
	class frame_time_scoreboard;
		logic [TICK_RATE_W-1:0] tick_rate;
		logic [FIXED_W-1:0]     fixed_step;
		logic [MAX_STEP_W-1:0]  max_step;
		logic [SCALE_W-1:0]     dilation;
		logic                   smoothing;
		logic [WINDOW_W-1:0]    window;
		logic [HIST_W-1:0]      hist [DEPTH];
		logic [US_W-1:0]        last_avg;
		frame_result_t          expected_q [$];
		int                     errors;

		function new();
			tick_rate  = RST_TICK_RATE;
			fixed_step = '0;
			max_step   = RST_MAX_STEP;
			dilation   = RST_SCALE;
			smoothing  = 1'b1;
			window     = RST_WINDOW;
			last_avg   = 24'(INIT_US);
			foreach (hist[i])
				hist[i] = INIT_US;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TICK_RATE: tick_rate  = data[TICK_RATE_W-1:0];
				CFG_FIXED:     fixed_step = data[FIXED_W-1:0];
				CFG_MAX_STEP:  max_step   = data[MAX_STEP_W-1:0];
				CFG_SCALE:     dilation   = data[SCALE_W-1:0];
				CFG_SMOOTH:    smoothing  = data[0];
				CFG_WINDOW:    window     = data[WINDOW_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the history and average by one frame and return its item
		function frame_result_t frame_step(logic [TICKS_W-1:0] ticks);
			logic [63:0]        quo;
			logic [63:0]        scaled;
			logic [63:0]        win;
			logic [63:0]        acc;
			logic [MAX_STEP_W-1:0] base;
			logic [US_W-1:0]    real_t;
			logic [US_W-1:0]    frame_t;
			logic [US_W-1:0]    avg;
			logic [HIST_W-1:0]  clip;
			frame_result_t      r;

			// convert ticks to whole microseconds, saturating
			if (tick_rate == '0) begin
				real_t = SAT24;
			end else begin
				quo = (64'(ticks) * 64'd1000000) / 64'(tick_rate);
				real_t = (quo > 64'(SAT24)) ? SAT24 : quo[US_W-1:0];
			end

			// fixed step overrides; otherwise clamp and scale the real time
			if (fixed_step != '0) begin
				if (fixed_step[FIXED_W-1])
					frame_t = 24'h200000 - {3'b000, fixed_step};
				else
					frame_t = {3'b000, fixed_step};
			end else begin
				base = (real_t < 24'(max_step)) ? real_t[MAX_STEP_W-1:0] : max_step;
				scaled = (64'(base) * 64'(dilation)) >> 8;
				frame_t = (scaled > 64'(SAT24)) ? SAT24 : scaled[US_W-1:0];
			end

			r.real_us = real_t;
			r.window_len = '0;

			// push the clipped sample and average over the time window
			if (smoothing) begin
				clip = (frame_t > 24'(CLIP_US)) ? CLIP_US : frame_t[HIST_W-1:0];
				for (int i = DEPTH - 1; i > 0; i--)
					hist[i] = hist[i-1];
				hist[0] = clip;
				win = 64'd1;
				if (last_avg != '0) begin
					win = (64'(window) * 2 + 64'(last_avg)) / (64'(last_avg) * 2);
					if (win > 64'(DEPTH))
						win = 64'(DEPTH);
					if (win < 64'd1)
						win = 64'd1;
				end
				acc = '0;
				for (int i = 0; i < int'(win); i++)
					acc += 64'(hist[i]);
				avg = 24'(acc / win);
				if (clip < SMALL_US)
					avg = 24'(clip);
				last_avg = avg;
				frame_t = avg;
				r.window_len = 7'(win);
			end
			r.frame_us = frame_t;
			return r;
		endfunction

		function void note_sample(logic [TICKS_W-1:0] ticks);
			expected_q.push_back(frame_step(ticks));
		endfunction

		function void report(string field, longint unsigned want, longint unsigned got);
			errors++;
			if (errors <= REPORT_N)
				$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field,
					want, got);
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;

			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= REPORT_N)
					$display("[%0t] unexpected item: frame_us %0d real_us %0d window_len %0d",
						$realtime, got.frame_us, got.real_us, got.window_len);
				return;
			end
			want = expected_q.pop_front();
			if (got.frame_us !== want.frame_us)
				report("frame_us", want.frame_us, got.frame_us);
			if (got.real_us !== want.real_us)
				report("real_us", want.real_us, got.real_us);
			if (got.window_len !== want.window_len)
				report("window_len", want.window_len, got.window_len);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           in_idle_pct;
	int unsigned           out_idle_pct;
	int unsigned           cycles;

	frame_time_scoreboard sb = new();

	fts_in_if  in_ch ();
	fts_out_if out_ch ();

	frame_time_smoother_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (in_ch),
		.result    (out_ch)
	);

	// clock
	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// drop the run if it hangs
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stall the result channel at random
	always @(negedge clk) begin
		out_ch.ready = ($urandom_range(0, 99) >= out_idle_pct);
	end

	// watch both channels at the rising edge
	always @(posedge clk) begin : monitor
		frame_result_t got;

		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got.frame_us   = out_ch.frame_us;
				got.real_us    = out_ch.real_us;
				got.window_len = out_ch.window_len;
				sb.check_result(got);
			end
			if (in_ch.valid && in_ch.ready)
				sb.note_sample(in_ch.elapsed_ticks);
		end
	end

	// Offer one item, with random gaps ahead of it, and hold it until taken
	task automatic send_sample(input logic [TICKS_W-1:0] ticks);
		@(negedge clk);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.elapsed_ticks = ticks;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
	endtask

	// Release the sample channel and wait until every expected item is back
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write one register while the block is idle
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Mostly plausible frame times at the current rate, some tiny, wild or extreme
	function automatic logic [TICKS_W-1:0] gen_ticks(logic [TICK_RATE_W-1:0] rate);
		int unsigned pick;
		logic [63:0] us;
		logic [63:0] t;

		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			us = (pick < 65) ? 64'($urandom_range(2000, 60000)) : 64'($urandom_range(0, 160));
			t = (rate == '0) ? us : (us * 64'(rate)) / 64'd1000000;
		end else if (pick < 90) begin
			t = {$urandom, $urandom};
		end else begin
			case ($urandom_range(0, 2))
				0: t = '0;
				1: t = {TICKS_W{1'b1}};
				default: t = 64'd1 << $urandom_range(0, TICKS_W - 1);
			endcase
		end
		return t[TICKS_W-1:0];
	endfunction

	// Pick a fresh register setting, extremes included
	task automatic random_setting();
		int signed   fs;
		logic [31:0] v;

		case ($urandom_range(0, 4))
			0, 1: v = 32'd1000000;
			2: v = 32'd1000;
			3: v = 32'hFFFF_FFFF;
			default: v = $urandom_range(1000, 32'hFFFF_FFFF);
		endcase
		set_reg(CFG_TICK_RATE, v);

		fs = 0;
		case ($urandom_range(0, 11))
			0: fs = 1000000;
			1: fs = -1000000;
			2: fs = int'($urandom_range(0, 2000000)) - 1000000;
			default: fs = 0;
		endcase
		set_reg(CFG_FIXED, 32'(fs) & 32'h1F_FFFF);

		case ($urandom_range(0, 5))
			0: v = 32'd0;
			1: v = 32'd1000000;
			2: v = 32'd250000;
			default: v = $urandom_range(20000, 1000000);
		endcase
		set_reg(CFG_MAX_STEP, v);

		case ($urandom_range(0, 7))
			0: v = 32'd0;
			1: v = 32'd65535;
			2: v = $urandom_range(0, 65535);
			3: v = $urandom_range(128, 512);
			default: v = 32'd256;
		endcase
		set_reg(CFG_SCALE, v);

		set_reg(CFG_SMOOTH, ($urandom_range(0, 99) < 85) ? 32'd1 : 32'd0);

		case ($urandom_range(0, 5))
			0: v = 32'd1;
			1: v = 32'd1000000;
			2: v = 32'd250000;
			default: v = $urandom_range(1, 1000000);
		endcase
		set_reg(CFG_WINDOW, v);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.elapsed_ticks = '0;
		out_ch.ready = 1'b0;
		in_idle_pct = 18;
		out_idle_pct = 79;

		// hold reset, then release away from the rising edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero, one, saturating ticks, small samples, max step clamp
		send_sample('0);
		send_sample(40'd1);
		send_sample({TICKS_W{1'b1}});
		send_sample(40'd33333);
		send_sample(40'd99);
		send_sample(40'd100);
		send_sample(40'd250001);

		// zero tick rate saturates the real time
		set_reg(CFG_TICK_RATE, 32'd0);
		send_sample(40'd5);
		set_reg(CFG_TICK_RATE, 32'd1000000);

		// fixed step, negative and positive, largest magnitude
		set_reg(CFG_FIXED, 32'h10_0000);
		send_sample(40'd12345);
		set_reg(CFG_FIXED, 32'd1000000);
		send_sample(40'd12345);
		set_reg(CFG_FIXED, 32'h1F_FFFF);
		send_sample(40'd12345);
		set_reg(CFG_FIXED, 32'(-1000000) & 32'h1F_FFFF);
		send_sample(40'd12345);
		set_reg(CFG_FIXED, 32'd0);

		// scaled frame time saturates
		set_reg(CFG_MAX_STEP, 32'd1000000);
		set_reg(CFG_SCALE, 32'd65535);
		send_sample(40'd1000000);

		// zero scale drives the average to zero, then the window falls to one
		set_reg(CFG_SCALE, 32'd0);
		send_sample(40'd50000);
		send_sample(40'd20000);

		// shortest and longest averaging periods
		set_reg(CFG_SCALE, 32'd256);
		set_reg(CFG_WINDOW, 32'd1);
		send_sample(40'd30000);
		set_reg(CFG_WINDOW, 32'd1000000);
		send_sample(40'd2000);
		send_sample(40'd2000);
		send_sample(40'd2000);
		set_reg(CFG_WINDOW, 32'hF_FFFF);
		send_sample(40'd2000);

		// smoothing off leaves the history alone
		set_reg(CFG_SMOOTH, 32'd0);
		send_sample(40'd77777);
		send_sample(40'h12_3456_789A);

		// random phases: sender light and receiver heavy, then swapped, then none
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_idle();
			if (seg < 4) begin
				in_idle_pct = 18;
				out_idle_pct = 79;
			end else if (seg < 7) begin
				in_idle_pct = 79;
				out_idle_pct = 18;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			random_setting();
			for (int n = 0; n < SEG_ITEMS; n++)
				send_sample(gen_ticks(sb.tick_rate));
		end

		// drain, then give stray items time to show up
		wait_idle();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
